FILE: design/vn_pkg.sv
// shared constants and types for the 3d vector normalizer
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 32;
    localparam int SQ_W       = 2 * IN_W;
    localparam int ROOT_W     = IN_W;
    localparam int K_W        = 5;
    localparam int NORM_STEPS = 5;

    typedef struct packed {
        logic [2:0][IN_W-1:0] mag;
        logic [2:0]           neg;
        logic [K_W-1:0]       k;
        logic                 zero;
    } t_side;

endpackage
`default_nettype wire

FILE: design/vn_if.sv
// input and output channel interfaces of the normalizer
`timescale 1ns / 1ps
`default_nettype none
interface vn_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [vn_pkg::IN_W-1:0]    vec_x;
    logic signed [vn_pkg::IN_W-1:0]    vec_y;
    logic signed [vn_pkg::IN_W-1:0]    vec_z;

    modport source (output valid, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface vn_out_if #(
    parameter int OUT_W = vn_pkg::FRAC_BITS + 2
);
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;

    modport source (output valid, unit_x, unit_y, unit_z, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, output ready);
endinterface
`default_nettype wire

FILE: design/vn_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module vn_sqrt_pipe #(
    parameter int SIDE_W = 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [vn_pkg::SQ_W-1:0]     i_rad,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic                             o_valid,
    output logic [vn_pkg::ROOT_W-1:0]        o_root,
    output logic [SIDE_W-1:0]                o_side
);
    localparam int NS    = vn_pkg::ROOT_W;
    localparam int REM_W = vn_pkg::ROOT_W + 3;
    localparam int RW    = vn_pkg::ROOT_W;
    localparam int AW    = vn_pkg::SQ_W;

    logic [REM_W-1:0]  r_rem  [0:NS-1];
    logic [RW-1:0]     r_root [0:NS-1];
    logic [AW-1:0]     r_rad  [0:NS-1];
    logic [SIDE_W-1:0] r_side [0:NS-1];
    logic              r_v    [0:NS-1];

    logic [REM_W-1:0]  n_rem  [0:NS-1];
    logic [RW-1:0]     n_root [0:NS-1];
    logic [AW-1:0]     n_rad  [0:NS-1];

    always_comb begin
        logic [REM_W-1:0] pr;
        logic [RW-1:0]    pq;
        logic [AW-1:0]    pa;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] trial;
        logic             ge;
        for (int j = 0; j < NS; j++) begin
            if (j == 0) begin
                pr = '0;
                pq = '0;
                pa = i_rad;
            end else begin
                pr = r_rem[j-1];
                pq = r_root[j-1];
                pa = r_rad[j-1];
            end
            // bring down the next two radicand bits
            sh    = {pr[REM_W-3:0], pa[AW-1:AW-2]};
            trial = REM_W'({pq, 2'b01});
            ge    = (sh >= trial);
            n_rem[j]  = ge ? (sh - trial) : sh;
            n_root[j] = {pq[RW-2:0], ge};
            n_rad[j]  = {pa[AW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 0; j < NS; j++) r_v[j] <= (j == 0) ? i_valid : r_v[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NS; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_rad[j]  <= n_rad[j];
                r_side[j] <= (j == 0) ? i_side : r_side[j-1];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_side  = r_side[NS-1];
endmodule
`default_nettype wire

FILE: design/vn_div_pipe.sv
// pipelined restoring divider giving a rounded ratio of component to length
`timescale 1ns / 1ps
`default_nettype none
module vn_div_pipe #(
    parameter int FRAC_BITS = vn_pkg::FRAC_BITS,
    parameter int SIDE_W    = 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [vn_pkg::IN_W-1:0]     i_n,
    input  wire logic [vn_pkg::ROOT_W-1:0]   i_len,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic                             o_valid,
    output logic [FRAC_BITS:0]               o_q,
    output logic [SIDE_W-1:0]                o_side
);
    localparam int QW    = FRAC_BITS + 1;
    localparam int DW    = vn_pkg::ROOT_W + 1;
    localparam int NUM_W = vn_pkg::IN_W + QW + 1;
    localparam int NS    = QW + 1;

    logic [DW-1:0]     r_rem  [0:NS-1];
    logic [QW-1:0]     r_low  [0:NS-1];
    logic [QW-1:0]     r_q    [0:NS-1];
    logic [DW-1:0]     r_d    [0:NS-1];
    logic [SIDE_W-1:0] r_side [0:NS-1];
    logic              r_v    [0:NS-1];

    logic [DW-1:0]     n_rem  [0:NS-1];
    logic [QW-1:0]     n_low  [0:NS-1];
    logic [QW-1:0]     n_q    [0:NS-1];
    logic [DW-1:0]     n_d    [0:NS-1];

    always_comb begin
        logic [NUM_W-1:0] num;
        logic [DW:0]      t;
        logic             ge;
        // numerator n * 2^(frac+1) + len, divisor 2 * len gives round half up
        num      = {1'b0, i_n, {QW{1'b0}}} + NUM_W'(i_len);
        n_rem[0] = num[QW+DW-1:QW];
        n_low[0] = num[QW-1:0];
        n_q[0]   = '0;
        n_d[0]   = {i_len, 1'b0};
        for (int j = 1; j < NS; j++) begin
            t  = {r_rem[j-1], r_low[j-1][QW-1]};
            ge = (t >= {1'b0, r_d[j-1]});
            n_rem[j] = ge ? DW'(t - {1'b0, r_d[j-1]}) : t[DW-1:0];
            n_low[j] = {r_low[j-1][QW-2:0], 1'b0};
            n_q[j]   = {r_q[j-1][QW-2:0], ge};
            n_d[j]   = r_d[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 0; j < NS; j++) r_v[j] <= (j == 0) ? i_valid : r_v[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NS; j++) begin
                r_rem[j]  <= n_rem[j];
                r_low[j]  <= n_low[j];
                r_q[j]    <= n_q[j];
                r_d[j]    <= n_d[j];
                r_side[j] <= (j == 0) ? i_side : r_side[j-1];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_q     = r_q[NS-1];
    assign o_side  = r_side[NS-1];
endmodule
`default_nettype wire

FILE: design/vn_out_fifo.sv
// two-entry output queue that decouples the pipeline from the receiver
`timescale 1ns / 1ps
`default_nettype none
module vn_out_fifo #(
    parameter int DATA_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_room,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data,
    input  wire logic              i_ready
);
    logic [DATA_W-1:0] r_data [0:1];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_room  = (r_cnt != 2'd2);
    assign o_data  = r_data[r_rp];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_data[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

FILE: design/vector_normalize_3d.sv
// 3d vector normalizer: top level
// Scales a vector of three signed Q16.16 components to unit length and
// returns the components as signed values with two integer bits and
// FRAC_BITS fraction bits. The zero vector gives the zero vector.
// Input channel i_vec carries vec_x, vec_y, vec_z; output channel o_unit
// carries unit_x, unit_y, unit_z. A beat moves when valid and ready are high.
// Throughput: one vector per cycle while the output queue has a free slot.
// From the input beat a vector passes the magnitude register, the square and
// sum registers, the even normalizing shift stages, the one-bit-per-stage
// square root, the divider and the output queue before output valid rises.
// The pipeline advances as one while the two-entry output queue has a free
// slot, so input ready is registered and stays high while one result waits.
// When the receiver stalls, the queue fills and the pipeline freezes with
// all items held; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and the queue.
`timescale 1ns / 1ps
`default_nettype none
module vector_normalize_3d #(
    parameter int FRAC_BITS = vn_pkg::FRAC_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vn_in_if.sink      i_vec,
    vn_out_if.source   o_unit
);
    localparam int IN_W   = vn_pkg::IN_W;
    localparam int SQ_W   = vn_pkg::SQ_W;
    localparam int K_W    = vn_pkg::K_W;
    localparam int NSTEP  = vn_pkg::NORM_STEPS;
    localparam int SIDE_W = $bits(vn_pkg::t_side);
    localparam int OUT_W  = FRAC_BITS + 2;

    logic w_en;

    // stage a: magnitudes and signs
    logic              r_a_v;
    logic [2:0][IN_W-1:0] r_a_mag;
    logic [2:0]        r_a_neg;
    // stage b: squares
    logic              r_b_v;
    logic [2:0][SQ_W-1:0] r_b_sq;
    vn_pkg::t_side     r_b_side;
    // stage c: sum
    logic              r_c_v;
    logic [SQ_W-1:0]   r_c_sum;
    vn_pkg::t_side     r_c_side;
    // normalizing stages
    logic              r_n_v    [0:NSTEP-1];
    logic [SQ_W-1:0]   r_n_s    [0:NSTEP-1];
    vn_pkg::t_side     r_n_side [0:NSTEP-1];
    logic [SQ_W-1:0]   n_n_s    [0:NSTEP-1];
    vn_pkg::t_side     n_n_side [0:NSTEP-1];

    logic [2:0][IN_W-1:0] w_in;

    assign w_in[0] = i_vec.vec_x;
    assign w_in[1] = i_vec.vec_y;
    assign w_in[2] = i_vec.vec_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            for (int t = 0; t < NSTEP; t++) r_n_v[t] <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_vec.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            for (int t = 0; t < NSTEP; t++) r_n_v[t] <= (t == 0) ? r_c_v : r_n_v[t-1];
        end
    end

    always_comb begin
        logic [SQ_W-1:0] ps;
        vn_pkg::t_side   psd;
        for (int t = 0; t < NSTEP; t++) begin
            if (t == 0) begin
                ps  = r_c_sum;
                psd = r_c_side;
            end else begin
                ps  = r_n_s[t-1];
                psd = r_n_side[t-1];
            end
            n_n_side[t] = psd;
            // shift by an even count while the top bits are clear
            if ((ps >> (SQ_W - (32 >> t))) == '0) begin
                n_n_s[t]      = ps << (32 >> t);
                n_n_side[t].k = psd.k + K_W'(16 >> t);
            end else begin
                n_n_s[t] = ps;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_neg[i] <= w_in[i][IN_W-1];
                r_a_mag[i] <= w_in[i][IN_W-1] ? (~w_in[i] + 1'b1) : w_in[i];
                r_b_sq[i]  <= SQ_W'(r_a_mag[i]) * SQ_W'(r_a_mag[i]);
            end
            r_b_side <= '{mag: r_a_mag, neg: r_a_neg, k: '0, zero: (r_a_mag == '0)};

            r_c_sum  <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            r_c_side <= r_b_side;

            for (int t = 0; t < NSTEP; t++) begin
                r_n_s[t]    <= n_n_s[t];
                r_n_side[t] <= n_n_side[t];
            end
        end
    end

    // square root of the normalized sum
    logic                        w_sq_v;
    logic [vn_pkg::ROOT_W-1:0]   w_len;
    logic [SIDE_W-1:0]           w_sq_side_raw;
    vn_pkg::t_side               w_sq_side;

    vn_sqrt_pipe #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_n_v[NSTEP-1]),
        .i_rad   (r_n_s[NSTEP-1]),
        .i_side  (r_n_side[NSTEP-1]),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_side  (w_sq_side_raw)
    );

    assign w_sq_side = vn_pkg::t_side'(w_sq_side_raw);

    // one divider per component
    logic [2:0]              w_dv_v;
    logic [2:0][FRAC_BITS:0] w_q;
    logic [2:0][1:0]         w_dv_side;
    logic [2:0][OUT_W-1:0]   w_unit;

    for (genvar g = 0; g < 3; g++) begin : g_div
        logic [2*IN_W-2:0] w_shifted;

        // mag * 2^k stays below 2^32 by the choice of k
        assign w_shifted = (2*IN_W-1)'(w_sq_side.mag[g]) << w_sq_side.k;

        vn_div_pipe #(
            .FRAC_BITS (FRAC_BITS),
            .SIDE_W    (2)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v),
            .i_n     (w_shifted[IN_W-1:0]),
            .i_len   (w_len),
            .i_side  ({w_sq_side.neg[g], w_sq_side.zero}),
            .o_valid (w_dv_v[g]),
            .o_q     (w_q[g]),
            .o_side  (w_dv_side[g])
        );

        always_comb begin
            logic [OUT_W-1:0] mag;
            if (w_q[g] > (FRAC_BITS+1)'(1 << FRAC_BITS))
                mag = OUT_W'(1 << FRAC_BITS);
            else
                mag = {1'b0, w_q[g]};
            if (w_dv_side[g][0])
                w_unit[g] = '0;
            else if (w_dv_side[g][1])
                w_unit[g] = ~mag + 1'b1;
            else
                w_unit[g] = mag;
        end
    end

    logic [3*OUT_W-1:0] w_fifo_data;

    vn_out_fifo #(
        .DATA_W (3*OUT_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_dv_v[0]),
        .i_data  ({w_unit[2], w_unit[1], w_unit[0]}),
        .o_room  (w_en),
        .o_valid (o_unit.valid),
        .o_data  (w_fifo_data),
        .i_ready (o_unit.ready)
    );

    assign i_vec.ready   = w_en;
    assign o_unit.unit_x = w_fifo_data[OUT_W-1:0];
    assign o_unit.unit_y = w_fifo_data[2*OUT_W-1:OUT_W];
    assign o_unit.unit_z = w_fifo_data[3*OUT_W-1:2*OUT_W];
endmodule
`default_nettype wire
